[src/i2cbm_pkg.sv]
// i2cbm_pkg: shared types and constants of the bit-level i2c master
// no dependencies; imported by i2cbm_seq and i2c_bit_level_master
package i2cbm_pkg;

  // command codes carried by an item
  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_SEND_BYTE = 3'd3,
    ACT_READ_BYTE = 3'd4,
    ACT_WAIT_ACK  = 3'd5,
    ACT_SEND_ACK  = 3'd6,
    ACT_SEND_NACK = 3'd7
  } action_e;

  // sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_ST_A  = 5'd1,
    PH_ST_B  = 5'd2,
    PH_ST_C  = 5'd3,
    PH_SP_A  = 5'd4,
    PH_SP_B  = 5'd5,
    PH_SP_C  = 5'd6,
    PH_TX_LO = 5'd7,
    PH_TX_HI = 5'd8,
    PH_RX_LO = 5'd9,
    PH_RX_HI = 5'd10,
    PH_RA_LO = 5'd11,
    PH_RA_HI = 5'd12,
    PH_WA_LO = 5'd13,
    PH_WA_HI = 5'd14,
    PH_AK_LO = 5'd15,
    PH_AK_HI = 5'd16
  } phase_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT  = 1'd1;

  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] PollLimitReset = 16'd300;
  localparam int unsigned HalfPeriodReset = 5;
  localparam logic [3:0] BitsPerByte = 4'd8;

  // one input item
  typedef struct packed {
    action_e    action;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_sample;
  } item_t;

  // one result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
    logic       timed_out;
  } res_t;

endpackage

[src/i2cbm_seq.sv]
// i2cbm_seq: bus phase sequencer state and its one-tick update logic
// depends on i2cbm_pkg; advances one tick on each step strobe
module i2cbm_seq import i2cbm_pkg::*; #(
  parameter int unsigned HalfPeriodWidth = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  item_t                      item_i,
  input  logic [HalfPeriodWidth-1:0] half_period_i,
  input  logic [15:0]                poll_limit_i,
  output res_t                       res_o
);

  phase_e                     phase_q, phase_d;
  logic [3:0]                 bit_cnt_q, bit_cnt_d;
  logic [7:0]                 shift_q, shift_d;
  logic [HalfPeriodWidth-1:0] timer_q, timer_d;
  logic [15:0]                poll_q, poll_d;
  logic                       scl_q, scl_d;
  logic                       sda_q, sda_d;
  logic                       en_q, en_d;
  logic [1:0]                 ack_q, ack_d;
  logic [7:0]                 rx_hold_q, rx_hold_d;
  logic                       rd_ack_q, rd_ack_d;
  logic                       done;

  logic [HalfPeriodWidth-1:0] hp, timer_inc;
  logic [15:0]                lim, poll_inc;
  logic [3:0]                 cnt_inc;
  logic [7:0]                 shl_tx, shl_rx;

  // zero settings behave as one
  assign hp        = (half_period_i == '0) ? HalfPeriodWidth'(1) : half_period_i;
  assign lim       = (poll_limit_i == '0) ? 16'd1 : poll_limit_i;
  assign timer_inc = timer_q + HalfPeriodWidth'(1);
  assign poll_inc  = poll_q + 16'd1;
  assign cnt_inc   = bit_cnt_q + 4'd1;
  assign shl_tx    = {shift_q[6:0], 1'b0};
  assign shl_rx    = {shift_q[6:0], item_i.sda_sample};

  // next state for one tick
  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    timer_d   = timer_q;
    poll_d    = poll_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    en_d      = en_q;
    ack_d     = ack_q;
    rx_hold_d = rx_hold_q;
    rd_ack_d  = rd_ack_q;
    done      = 1'b0;

    if (phase_q == PH_IDLE) begin
      // new command; first phase shows on this tick
      bit_cnt_d = '0;
      case (item_i.action)
        ACT_START: begin
          phase_d = PH_ST_A; timer_d = '0; scl_d = 1'b0; sda_d = 1'b1; en_d = 1'b1;
        end
        ACT_STOP: begin
          phase_d = PH_SP_A; timer_d = '0; scl_d = 1'b0; sda_d = 1'b0; en_d = 1'b1;
        end
        ACT_SEND_BYTE: begin
          shift_d = item_i.tx_byte;
          phase_d = PH_TX_LO; timer_d = '0; scl_d = 1'b0;
          sda_d   = item_i.tx_byte[7]; en_d = 1'b1;
        end
        ACT_READ_BYTE: begin
          shift_d  = '0;
          rd_ack_d = item_i.ack_after_read;
          phase_d  = PH_RX_LO; timer_d = '0; scl_d = 1'b0; en_d = 1'b0;
        end
        ACT_WAIT_ACK: begin
          phase_d = PH_WA_LO; timer_d = '0; scl_d = 1'b0; en_d = 1'b0;
        end
        ACT_SEND_ACK: begin
          phase_d = PH_AK_LO; timer_d = '0; scl_d = 1'b0; sda_d = 1'b0; en_d = 1'b1;
        end
        ACT_SEND_NACK: begin
          phase_d = PH_AK_LO; timer_d = '0; scl_d = 1'b0; sda_d = 1'b1; en_d = 1'b1;
        end
        default: ;
      endcase
    end else if (phase_q == PH_WA_HI) begin
      // ack poll: low sample ends it, else count toward timeout
      if (!item_i.sda_sample) begin
        ack_d   = 2'b00;
        phase_d = PH_IDLE; timer_d = '0; scl_d = 1'b0; en_d = 1'b0;
        done    = 1'b1;
      end else begin
        poll_d = poll_inc;
        if (poll_inc >= lim) begin
          ack_d   = 2'b11;
          phase_d = PH_SP_A; timer_d = '0; scl_d = 1'b0; sda_d = 1'b0; en_d = 1'b1;
        end
      end
    end else begin
      timer_d = timer_inc;
      // phase boundary
      if (timer_inc >= hp || timer_inc == '0) begin
        timer_d = '0;
        case (phase_q)
          PH_ST_A: begin phase_d = PH_ST_B; scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b1; end
          PH_ST_B: begin phase_d = PH_ST_C; scl_d = 1'b1; sda_d = 1'b0; en_d = 1'b1; end
          PH_ST_C: begin
            phase_d = PH_IDLE; scl_d = 1'b0; sda_d = 1'b0; en_d = 1'b1; done = 1'b1;
          end
          PH_SP_A: begin phase_d = PH_SP_B; scl_d = 1'b1; sda_d = 1'b0; en_d = 1'b1; end
          PH_SP_B: begin phase_d = PH_SP_C; scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b1; end
          PH_SP_C: begin
            phase_d = PH_IDLE; scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b0; done = 1'b1;
          end
          PH_TX_LO: begin phase_d = PH_TX_HI; scl_d = 1'b1; en_d = 1'b1; end
          PH_TX_HI: begin
            shift_d   = shl_tx;
            bit_cnt_d = cnt_inc;
            if (cnt_inc >= BitsPerByte) begin
              phase_d = PH_IDLE; scl_d = 1'b0; en_d = 1'b1; done = 1'b1;
            end else begin
              phase_d = PH_TX_LO; scl_d = 1'b0; sda_d = shl_tx[7]; en_d = 1'b1;
            end
          end
          PH_RX_LO: begin phase_d = PH_RX_HI; scl_d = 1'b1; en_d = 1'b0; end
          PH_RX_HI: begin
            // sample shifted in at the end of the high half
            shift_d   = shl_rx;
            bit_cnt_d = cnt_inc;
            if (cnt_inc >= BitsPerByte) begin
              rx_hold_d = shl_rx;
              phase_d   = PH_RA_LO; scl_d = 1'b0; sda_d = ~rd_ack_q; en_d = 1'b1;
            end else begin
              phase_d = PH_RX_LO; scl_d = 1'b0; en_d = 1'b0;
            end
          end
          PH_RA_LO: begin phase_d = PH_RA_HI; scl_d = 1'b1; en_d = 1'b1; end
          PH_RA_HI: begin
            phase_d = PH_IDLE; scl_d = 1'b0; en_d = 1'b1; done = 1'b1;
          end
          PH_WA_LO: begin
            poll_d  = '0;
            phase_d = PH_WA_HI; scl_d = 1'b1; en_d = 1'b0;
          end
          PH_AK_LO: begin phase_d = PH_AK_HI; scl_d = 1'b1; en_d = 1'b1; end
          PH_AK_HI: begin
            phase_d = PH_IDLE; scl_d = 1'b0; en_d = 1'b1; done = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE; done = 1'b1;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      timer_q   <= '0;
      poll_q    <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      en_q      <= 1'b0;
      ack_q     <= '0;
      rx_hold_q <= '0;
      rd_ack_q  <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      timer_q   <= timer_d;
      poll_q    <= poll_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      en_q      <= en_d;
      ack_q     <= ack_d;
      rx_hold_q <= rx_hold_d;
      rd_ack_q  <= rd_ack_d;
    end
  end

  // result of this tick, values after the update
  always_comb begin
    res_o.scl_level        = scl_d;
    res_o.sda_level        = sda_d;
    res_o.sda_drive_enable = en_d;
    res_o.busy_res         = (phase_d != PH_IDLE);
    res_o.done_res         = done;
    res_o.rx_byte          = rx_hold_d;
    res_o.nack_seen        = ack_d[0];
    res_o.timed_out        = ack_d[1];
  end

  // done marks exactly a busy-to-idle transition
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (done == (phase_q != PH_IDLE && phase_d == PH_IDLE)))
    else $error("done does not match the end of a command");

  // a poll timeout turns into a stop with nack and timeout set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_WA_HI && item_i.sda_sample && poll_inc >= lim
    |=> phase_q == PH_SP_A && ack_q == 2'b11)
    else $error("ack poll timeout did not start a stop");

  // bit counter restarts on every idle tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_IDLE |=> bit_cnt_q == '0)
    else $error("bit counter not cleared while idle");

endmodule

[src/i2c_bit_level_master.sv]
// i2c_bit_level_master: top level with input register, sequencer and result register
// depends on i2cbm_pkg and i2cbm_seq
//
// Usage:
//   Each item on the input channel is one timing tick: the sampled SDA level
//   and, while idle, a command (start, stop, send byte, read byte, wait ack,
//   send ack, send nack). Every item yields exactly one result item holding
//   the SCL/SDA drive, the SDA output enable, busy, a done pulse, the last
//   read byte and the last wait-ack status.
//   The config channel writes half_period_ticks (index 0) and ack_poll_limit
//   (index 1) and is always ready; the user must write it only while idle
//   (not enforced by the block). Each item passes the input register, then
//   the sequencer update into the result register, to form its result item.
//   Throughput: one item per cycle while the result is taken; the sequencer
//   takes one tick per cycle and both registers advance together when the
//   result register is free. A stalled receiver holds the result; one item waits
//   in the input register and further items are refused until the result is taken.
//   Reset: bus released (SCL 1, SDA 1, enable 0), idle, status and read byte
//   zero, half period 5, poll limit 300; no item in flight.
module i2c_bit_level_master import i2cbm_pkg::*; #(
  parameter int unsigned HALF_PERIOD_WIDTH = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            action_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  ack_after_read_i,
  input  logic                  sda_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  scl_level_o,
  output logic                  sda_level_o,
  output logic                  sda_drive_enable_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic [7:0]            rx_byte_o,
  output logic                  nack_seen_o,
  output logic                  timed_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i
);

  logic                         in_valid_q;
  item_t                        item_q;
  logic                         out_valid_q;
  res_t                         res_q, res_d;
  logic                         adv;
  logic [HALF_PERIOD_WIDTH-1:0] hp_q;
  logic [15:0]                  lim_q;

  // move one item through the sequencer when the result slot frees
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q  <= HALF_PERIOD_WIDTH'(HalfPeriodReset);
      lim_q <= PollLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HALF_PERIOD: hp_q  <= cfg_wdata_i[HALF_PERIOD_WIDTH-1:0];
        CFG_POLL_LIMIT:  lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.action         <= action_e'(action_i);
      item_q.tx_byte        <= tx_byte_i;
      item_q.ack_after_read <= ack_after_read_i;
      item_q.sda_sample     <= sda_sample_i;
    end
  end

  i2cbm_seq #(
    .HalfPeriodWidth(HALF_PERIOD_WIDTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .item_i        (item_q),
    .half_period_i (hp_q),
    .poll_limit_i  (lim_q),
    .res_o         (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scl_level_o        = res_q.scl_level;
  assign sda_level_o        = res_q.sda_level;
  assign sda_drive_enable_o = res_q.sda_drive_enable;
  assign busy_res_o         = res_q.busy_res;
  assign done_res_o         = res_q.done_res;
  assign rx_byte_o          = res_q.rx_byte;
  assign nack_seen_o        = res_q.nack_seen;
  assign timed_out_o        = res_q.timed_out;

  // a waiting item is not dropped while the result stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q)
    else $error("held item lost");

  // a finished command never reports busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.done_res && res_q.busy_res))
    else $error("done and busy both set");

  // a stalled result stays valid and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

endmodule
